// ===== rtl/pfcw_pkg.sv =====
// Shared constants and the queue entry type of the packet framer.
package pfcw_pkg;

   // Whitening table length and the longest payload that still fits it.
   localparam int WhitenTableLen = 57;
   localparam int MaxPayload     = WhitenTableLen - 3;

   // CRC-16 settings: polynomial 0x8005, MSB first, preset to all ones.
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h8005;

   // Default depth of the queue between the front and the back.
   localparam int QueueDepth = 4;

   // One classified payload byte on its way to the back.
   typedef struct packed {
      logic [7:0]  data;
      logic [15:0] crc;
      logic [5:0]  len;
      logic [5:0]  pos;
      logic        first;
      logic        last;
   } entry_type;

   // Kind of beat that the back sends next for the entry at the queue head.
   typedef enum logic [3:0] {
      KIND_LEN  = 4'b0001,
      KIND_DATA = 4'b0010,
      KIND_CRCH = 4'b0100,
      KIND_CRCL = 4'b1000
   } kind_type;

endpackage

// ===== rtl/pfcw_front.sv =====
// Front end: frames payload bytes, tracks position and length, updates the CRC.
module pfcw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic [5:0]            req_payload_length,
   input  logic                  q_full,
   output logic                  q_push,
   output pfcw_pkg::entry_type   q_entry
);

   localparam logic [5:0] MaxLen = 6'(pfcw_pkg::MaxPayload);

   // One byte of CRC-16 update, eight shift steps.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ pfcw_pkg::CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Frame tracking at the input.
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  len_ff, len_in;

   // Classification stage register.
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_data_ff;
   logic [5:0]  a_len_ff;
   logic [5:0]  a_pos_ff;
   logic        a_first_ff;
   logic        a_last_ff;
   logic [15:0] a_lencrc_ff;

   // Running CRC, updated as entries enter the queue.
   logic [15:0] crc_ff, crc_in;

   logic        accept;
   logic        a_advance;
   logic        first;
   logic        last;
   logic [5:0]  len_sel;
   logic [5:0]  position;
   logic [5:0]  len_clamped;
   logic [15:0] crc_start;
   logic [15:0] crc_next;

   assign a_advance = !a_valid_ff || !q_full;
   assign req_stall = !a_advance;
   assign accept    = req_valid && a_advance;

   always_comb begin
      len_clamped = req_payload_length;
      if (req_payload_length == 6'd0) begin
         len_clamped = 6'd1;
      end else if (req_payload_length > MaxLen) begin
         len_clamped = MaxLen;
      end
      first    = (pos_ff == 6'd0);
      len_sel  = first ? len_clamped : len_ff;
      position = first ? 6'd1 : pos_ff;
      last     = (position >= len_sel);
      pos_in   = pos_ff;
      len_in   = len_ff;
      if (accept) begin
         pos_in = last ? 6'd0 : position + 6'd1;
         len_in = len_sel;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_advance) begin
         a_valid_in = req_valid;
      end
   end

   // The length byte's CRC does not depend on earlier frames, so it is
   // formed a stage ahead and only one byte update sits in the CRC loop.
   assign q_push    = a_valid_ff && !q_full;
   assign crc_start = a_first_ff ? a_lencrc_ff : crc_ff;
   assign crc_next  = crc_byte(crc_start, a_data_ff);

   always_comb begin
      crc_in = crc_ff;
      if (q_push) begin
         crc_in = a_last_ff ? pfcw_pkg::CrcInit : crc_next;
      end
   end

   always_comb begin
      q_entry.data  = a_data_ff;
      q_entry.crc   = crc_next;
      q_entry.len   = a_len_ff;
      q_entry.pos   = a_pos_ff;
      q_entry.first = a_first_ff;
      q_entry.last  = a_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 6'd0;
         len_ff     <= 6'd0;
         a_valid_ff <= 1'b0;
         crc_ff     <= pfcw_pkg::CrcInit;
      end else begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         a_valid_ff <= a_valid_in;
         crc_ff     <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_data_ff   <= req_data_byte;
         a_len_ff    <= len_sel;
         a_pos_ff    <= position;
         a_first_ff  <= first;
         a_last_ff   <= last;
         a_lencrc_ff <= crc_byte(pfcw_pkg::CrcInit, {2'b00, len_clamped});
      end
   end

endmodule

// ===== rtl/pfcw_queue.sv =====
// Short first-in first-out queue of classified bytes between front and back.
module pfcw_queue #(
   parameter int DEPTH = pfcw_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pfcw_pkg::entry_type   push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output pfcw_pkg::entry_type   head_entry
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
   localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
   localparam logic [CntW-1:0] CntOne  = CntW'(1);

   pfcw_pkg::entry_type mem_ff [DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + PtrOne;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + PtrOne;
      end
      if (push && !pop) begin
         count_in = count_ff + CntOne;
      end else if (pop && !push) begin
         count_in = count_ff - CntOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/pfcw_back.sv =====
// Back end: expands queued bytes into whitened frame beats on the result channel.
module pfcw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  pfcw_pkg::entry_type   head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_frame_end
);

   // Whitening sequence by frame position; positions past the table give zero.
   function automatic logic [7:0] whiten(input logic [5:0] idx);
      logic [7:0] w;
      case (idx)
         6'd0:  w = 8'hff;  6'd1:  w = 8'he1;  6'd2:  w = 8'h1d;  6'd3:  w = 8'h9a;
         6'd4:  w = 8'hed;  6'd5:  w = 8'h85;  6'd6:  w = 8'h33;  6'd7:  w = 8'h24;
         6'd8:  w = 8'hea;  6'd9:  w = 8'h7a;  6'd10: w = 8'hd2;  6'd11: w = 8'h39;
         6'd12: w = 8'h70;  6'd13: w = 8'h97;  6'd14: w = 8'h57;  6'd15: w = 8'h0a;
         6'd16: w = 8'h54;  6'd17: w = 8'h7d;  6'd18: w = 8'h2d;  6'd19: w = 8'hd8;
         6'd20: w = 8'h6d;  6'd21: w = 8'h0d;  6'd22: w = 8'hba;  6'd23: w = 8'h8f;
         6'd24: w = 8'h67;  6'd25: w = 8'h59;  6'd26: w = 8'hc7;  6'd27: w = 8'ha2;
         6'd28: w = 8'hbf;  6'd29: w = 8'h34;  6'd30: w = 8'hca;  6'd31: w = 8'h18;
         6'd32: w = 8'h30;  6'd33: w = 8'h53;  6'd34: w = 8'h93;  6'd35: w = 8'hdf;
         6'd36: w = 8'h92;  6'd37: w = 8'hec;  6'd38: w = 8'ha7;  6'd39: w = 8'h15;
         6'd40: w = 8'h8a;  6'd41: w = 8'hdc;  6'd42: w = 8'hf4;  6'd43: w = 8'h86;
         6'd44: w = 8'h55;  6'd45: w = 8'h4e;  6'd46: w = 8'h18;  6'd47: w = 8'h21;
         6'd48: w = 8'h40;  6'd49: w = 8'hc4;  6'd50: w = 8'hc4;  6'd51: w = 8'hd5;
         6'd52: w = 8'hc6;  6'd53: w = 8'h91;  6'd54: w = 8'h8a;  6'd55: w = 8'hcd;
         6'd56: w = 8'he7;
         default: w = 8'h00;
      endcase
      return w;
   endfunction

   logic                 started_ff, started_in;
   pfcw_pkg::kind_type   kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_end_ff, rsp_end_in;

   pfcw_pkg::kind_type   cur_kind;
   pfcw_pkg::kind_type   next_kind;
   logic                 advance;
   logic                 emit;
   logic                 done;
   logic [5:0]           wpos;
   logic [7:0]           raw;
   logic                 is_end;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && head_valid;
   assign pop     = emit && done;

   always_comb begin
      if (started_ff) begin
         cur_kind = kind_ff;
      end else begin
         cur_kind = head_entry.first ? pfcw_pkg::KIND_LEN : pfcw_pkg::KIND_DATA;
      end
   end

   always_comb begin
      wpos      = head_entry.pos;
      raw       = head_entry.data;
      is_end    = 1'b0;
      done      = 1'b1;
      next_kind = pfcw_pkg::KIND_DATA;
      case (cur_kind)
         pfcw_pkg::KIND_LEN: begin
            wpos      = 6'd0;
            raw       = {2'b00, head_entry.len};
            done      = 1'b0;
            next_kind = pfcw_pkg::KIND_DATA;
         end
         pfcw_pkg::KIND_DATA: begin
            done      = !head_entry.last;
            next_kind = pfcw_pkg::KIND_CRCH;
         end
         pfcw_pkg::KIND_CRCH: begin
            wpos      = head_entry.pos + 6'd1;
            raw       = head_entry.crc[15:8];
            done      = 1'b0;
            next_kind = pfcw_pkg::KIND_CRCL;
         end
         pfcw_pkg::KIND_CRCL: begin
            wpos   = head_entry.pos + 6'd2;
            raw    = head_entry.crc[7:0];
            is_end = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      started_in   = started_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
         rsp_byte_in  = raw ^ whiten(wpos);
         rsp_end_in   = is_end;
      end
      if (emit) begin
         started_in = !done;
         kind_in    = next_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         kind_ff      <= pfcw_pkg::KIND_DATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

// ===== rtl/packet_framer_crc16_whiten_unit.sv =====
// Top level of the packet framer with CRC-16 and whitening.
// Path: each payload byte passes the stage register, the queue, then the output register.
// Throughput: one payload byte per cycle in while req_stall is low; a frame of n bytes
// leaves as n + 3 beats; the queue absorbs the extra beats until it is full and the input stalls.
// Reset: synchronous and active high; clears the queue, the frame tracker and the
// output valid flag, and presets the running CRC to all ones.
module packet_framer_crc16_whiten_unit #(
   parameter int QUEUE_DEPTH = pfcw_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end
);

   // The front end takes one payload beat per cycle while not stalled, samples the
   // length on the first byte of a frame, and tags each byte with its position and
   // whether it opens or closes the frame. The CRC is advanced one byte per entry that
   // enters the queue, so the running CRC loop is a single byte update.
   pfcw_pkg::entry_type push_entry;
   pfcw_pkg::entry_type head_entry;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                head_valid;

   pfcw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_payload_length (req_payload_length),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   // The queue absorbs the extra beats of a frame's head and tail, so the input
   // keeps flowing while the back end sends the length and CRC bytes, until the queue is full.
   pfcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back end turns each queued byte into one to four whitened beats and
   // holds them in an output register, flagging the low CRC byte as the end
   // of the frame.
   pfcw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== dv/packet_framer_crc16_whiten_unit_test.sv =====
// Self-checking testbench for the packet framer with CRC-16 and whitening.
`timescale 1ns / 100ps

module packet_framer_crc16_whiten_unit_test;

   // The run is short. This limit only catches a hung handshake.
   localparam int CycleLimit   = 60000;
   localparam int HoldOffBeats = 80;
   localparam int DrainCycles  = 8;

   // Whitening bytes, indexed by position in the frame. The length byte sits at
   // position zero, and the low CRC byte of the longest frame sits at 56.
   localparam logic [7:0] WhitenBytes [0:56] = '{
      8'hff, 8'he1, 8'h1d, 8'h9a, 8'hed, 8'h85, 8'h33, 8'h24, 8'hea, 8'h7a,
      8'hd2, 8'h39, 8'h70, 8'h97, 8'h57, 8'h0a, 8'h54, 8'h7d, 8'h2d, 8'hd8,
      8'h6d, 8'h0d, 8'hba, 8'h8f, 8'h67, 8'h59, 8'hc7, 8'ha2, 8'hbf, 8'h34,
      8'hca, 8'h18, 8'h30, 8'h53, 8'h93, 8'hdf, 8'h92, 8'hec, 8'ha7, 8'h15,
      8'h8a, 8'hdc, 8'hf4, 8'h86, 8'h55, 8'h4e, 8'h18, 8'h21, 8'h40, 8'hc4,
      8'hc4, 8'hd5, 8'hc6, 8'h91, 8'h8a, 8'hcd, 8'he7
   };

   // One beat on the result side, as the framer should send it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } frame_beat_type;

   // One row of the directed stimulus. Where a row opens a frame and the
   // whitened length byte is obvious, it is typed in as head_byte and stands
   // in for the computed value of the first beat that the row causes.
   typedef struct packed {
      logic [7:0] data;
      logic [5:0] length;
      logic       head_known;
      logic [7:0] head_byte;
   } stim_row_type;

   localparam int DirectedRows = 12;
   localparam stim_row_type DirectedStim [0:DirectedRows-1] = '{
      // A one-byte frame: length byte, payload byte and both CRC bytes from one row.
      '{8'h00, 6'd1,  1'b1, 8'hfe},
      // A length of zero is taken as one.
      '{8'hff, 6'd0,  1'b1, 8'hfe},
      // Two-byte frame whose second beat carries a length that must be ignored.
      '{8'h80, 6'd2,  1'b1, 8'hfd},
      '{8'h01, 6'd63, 1'b0, 8'h00},
      // Three-byte frame, again with junk lengths in the middle.
      '{8'h55, 6'd3,  1'b1, 8'hfc},
      '{8'haa, 6'd0,  1'b0, 8'h00},
      '{8'h7f, 6'd1,  1'b0, 8'h00},
      // Four-byte frame.
      '{8'hc3, 6'd4,  1'b1, 8'hfb},
      '{8'h3c, 6'd32, 1'b0, 8'h00},
      '{8'h0f, 6'd16, 1'b0, 8'h00},
      '{8'hf0, 6'd8,  1'b0, 8'h00},
      // Just past the largest payload: saturates to 54. The close_frame call after the
      // directed rows finishes this frame, so it has to stay the last row.
      '{8'h5a, 6'd55, 1'b1, 8'hc9}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic [5:0] req_payload_length = 6'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;

   packet_framer_crc16_whiten_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   always #5 clock = ~clock;

   // Framing state as the testbench tracks it. next_pos of zero means that the
   // next payload byte opens a new frame.
   logic [15:0] frame_crc = pfcw_pkg::CrcInit;
   logic [5:0]  next_pos  = 6'd0;
   logic [5:0]  frame_len = 6'd0;

   frame_beat_type pending_beats [$];
   int          beats_pushed = 0;
   int          mismatch_count = 0;
   int          bytes_taken = 0;
   int          cycle_count = 0;

   // Idle rates in percent; the main sequence changes them from phase to phase.
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   // The main sequence bumps hold_request to ask for one long stall on the
   // result side; the receiver process counts that stall out on its own.
   int          hold_request = 0;
   int          hold_served  = 0;
   int          hold_left    = 0;

   // MSB-first CRC-16 over one byte, polynomial 0x8005, no reflection.
   function automatic logic [15:0] crc16_add_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ pfcw_pkg::CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   function automatic void push_beat(int pos, logic [7:0] b, logic last);
      frame_beat_type beat;
      beat.out_byte  = b ^ WhitenBytes[pos];
      beat.frame_end = last;
      pending_beats.push_back(beat);
      beats_pushed++;
   endfunction

   // Works out the beats that one accepted payload byte causes and queues them.
   function automatic void frame_payload_byte(logic [7:0] data, logic [5:0] length);
      logic [5:0] clamped;
      logic [5:0] pos;
      if (next_pos == 6'd0) begin
         clamped = (length == 6'd0) ? 6'd1 : length;
         if (clamped > 6'(pfcw_pkg::MaxPayload)) begin
            clamped = 6'(pfcw_pkg::MaxPayload);
         end
         frame_len = clamped;
         frame_crc = crc16_add_byte(pfcw_pkg::CrcInit, {2'b00, clamped});
         push_beat(0, {2'b00, clamped}, 1'b0);
         next_pos = 6'd1;
      end
      pos = next_pos;
      frame_crc = crc16_add_byte(frame_crc, data);
      push_beat(pos, data, 1'b0);
      if (pos >= frame_len) begin
         // The CRC goes out high byte first; the low byte closes the frame.
         push_beat(pos + 1, frame_crc[15:8], 1'b0);
         push_beat(pos + 2, frame_crc[7:0], 1'b1);
         frame_crc = pfcw_pkg::CrcInit;
         next_pos  = 6'd0;
      end else begin
         next_pos = pos + 6'd1;
      end
   endfunction

   // Offers one payload byte, with a random idle gap first, and returns in the
   // time step of the edge that took it. The payload holds while stalled.
   task automatic send_payload_byte(logic [7:0] data, logic [5:0] length);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_payload_length <= length;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      frame_payload_byte(data, length);
      bytes_taken++;
   endtask

   // Completes any open frame with random bytes. The length field is random
   // too, since the framer must ignore it in the middle of a frame.
   task automatic close_frame();
      while (next_pos != 6'd0) begin
         send_payload_byte(8'($urandom), 6'($urandom));
      end
   endtask

   // Sends whole frames until at least n_bytes payload bytes have gone in.
   // Most frames are short; a few use zero or oversized lengths.
   task automatic send_random_frames(int n_bytes);
      int         start_count;
      int         pick;
      logic [5:0] length;
      start_count = bytes_taken;
      while (bytes_taken - start_count < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            length = 6'($urandom_range(40, 63));
         end else if (pick < 14) begin
            length = 6'd0;
         end else begin
            length = 6'($urandom_range(1, 8));
         end
         send_payload_byte(8'($urandom), length);
         close_frame();
      end
   endtask

   // Result side: random stall, or a long hold-off when one has been asked for.
   always @(posedge clock) begin
      if (hold_served != hold_request) begin
         hold_served = hold_request;
         hold_left   = HoldOffBeats;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Every beat taken on the result side is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected beat at cycle %0d: out_byte %02h frame_end %0b",
                        cycle_count, rsp_out_byte, rsp_frame_end);
            end
         end else begin
            want = pending_beats.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_frame_end !== want.frame_end) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Beat mismatch at cycle %0d: byte %02h (want %02h) end %0b (want %0b)",
                           cycle_count, rsp_out_byte, want.out_byte, rsp_frame_end,
                           want.frame_end);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int first_beat;
      int pushed_before;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender idles sometimes, the receiver often.
      send_idle_pct  = 30;
      recv_stall_pct = 69;
      for (int i = 0; i < DirectedRows; i++) begin
         pushed_before = beats_pushed;
         send_payload_byte(DirectedStim[i].data, DirectedStim[i].length);
         // Older beats may have left while this row waited, so the row's first
         // beat is found from the back of the queue.
         first_beat = pending_beats.size() - (beats_pushed - pushed_before);
         if (DirectedStim[i].head_known) begin
            pending_beats[first_beat].out_byte = DirectedStim[i].head_byte;
         end
      end
      close_frame();
      send_random_frames(10);

      // Second phase: the roles swap.
      send_idle_pct  = 69;
      recv_stall_pct = 30;
      send_random_frames(10);

      // Last phase: nobody idles, except for one long hold-off on the result
      // side while the sender keeps offering bytes, so the queue fills and the
      // framer has to stall its input.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request++;
      send_random_frames(10);
      req_valid <= 1'b0;

      while (pending_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
